// ----- src/epoch_seconds_to_calendar_date_defines.svh -----
// Assertion macros for the epoch seconds to calendar date block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, quiet while reset is held
`define ESCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escd: same-cycle check failed");

// Next-cycle implication, quiet while reset is held
`define ESCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escd: next-cycle check failed");

`endif

// ----- src/escd_pkg.sv -----
// Shared constants and types for the epoch seconds to calendar date block.
// No dependencies; imported by every module of the block.
package escd_pkg;

  // Field widths
  localparam int unsigned SECS_W   = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned OUT_DATA_W = 40;

  // Internal widths
  localparam int unsigned DAYS_W = 16;  // day count from the GPS epoch, up to 46053
  localparam int unsigned SOD_W  = 17;  // second of day
  localparam int unsigned MOD_W  = 11;  // minute of day
  localparam int unsigned QUAD_W = 5;   // four-year periods since 1980
  localparam int unsigned QD_W   = 11;  // day within a four-year period, 0..1460
  localparam int unsigned DOY_W  = 9;   // day of year, 0-based

  // 1980-01-06 expressed in seconds since 1970-01-01
  localparam logic [SECS_W-1:0] GPS_OFFSET = 32'd315964800;

  // days = (g >> 7) / 675, exact by reciprocal for 25-bit operands
  localparam logic [25:0]  DAY_RECIP = 26'd50903317;
  localparam int unsigned  DAY_SHIFT = 35;
  localparam logic [24:0]  DAY_ODD   = 25'd675;

  // 0-based day from 1980-01-01 is days + 5
  localparam logic [DAYS_W-1:0] DAY_BIAS = 16'd5;

  // four-year periods: x / 1461 by reciprocal, exact for x below 2^16
  localparam logic [15:0] QUAD_RECIP = 16'd45934;
  localparam int unsigned QUAD_SHIFT = 26;
  localparam logic [15:0] QUAD_DAYS  = 16'd1461;

  // hour: (sod >> 4) / 225; minute of day: (sod >> 2) / 15
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  localparam int unsigned HOUR_SHIFT = 20;
  localparam logic [15:0] MOD_RECIP  = 16'd34953;
  localparam int unsigned MOD_SHIFT  = 19;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1980;

  // First day (0-based) of each month in a common year
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

endpackage

// ----- src/escd_date.sv -----
// Day within a four-year period to year, month and day of month.
// Depends on escd_pkg for the month table and date_t.
module escd_date (
  input  logic [escd_pkg::QUAD_W-1:0] quad,
  input  logic [escd_pkg::QD_W-1:0]   quad_day,
  output escd_pkg::date_t             date
);
  import escd_pkg::*;

  logic [1:0]        yoff;
  logic [QD_W-1:0]   doy_w;
  logic [DOY_W-1:0]  doy;
  logic              leap;
  logic [DOY_W-1:0]  start;
  logic [DOY_W-1:0]  sel_start;
  logic [3:0]        sel_mon;
  logic [DOY_W-1:0]  dom0;

  always_comb begin
    // split the period: first year is the leap year
    if (quad_day < 11'd366) begin
      yoff  = 2'd0;
      doy_w = quad_day;
    end else if (quad_day < 11'd731) begin
      yoff  = 2'd1;
      doy_w = quad_day - 11'd366;
    end else if (quad_day < 11'd1096) begin
      yoff  = 2'd2;
      doy_w = quad_day - 11'd731;
    end else begin
      yoff  = 2'd3;
      doy_w = quad_day - 11'd1096;
    end
    doy  = doy_w[DOY_W-1:0];
    leap = (yoff == 2'd0);

    // pick the last month whose first day is not after doy
    sel_start = '0;
    sel_mon   = '0;
    for (int m = 0; m < 12; m++) begin
      start = MONTH_START[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
      if (doy >= start) begin
        sel_start = start;
        sel_mon   = 4'(m);
      end
    end
    dom0 = doy - sel_start;

    date.year  = BASE_YEAR + {5'd0, quad, 2'd0} + {10'd0, yoff};
    date.month = sel_mon + 4'd1;
    date.day   = dom0[DAY_W-1:0] + 5'd1;
  end

endmodule

// ----- src/escd_tod.sv -----
// Time of day: minute and second from hour, minute of day and second of day.
// Depends on escd_pkg for field widths.
module escd_tod (
  input  logic [escd_pkg::SOD_W-1:0]    sod,
  input  logic [escd_pkg::HOUR_W-1:0]   hour,
  input  logic [escd_pkg::MOD_W-1:0]    mod,
  output logic [escd_pkg::MINUTE_W-1:0] minute,
  output logic [escd_pkg::SECOND_W-1:0] second
);
  import escd_pkg::*;

  logic [MOD_W-1:0] hour_min;
  logic [MOD_W-1:0] min_diff;
  logic [SOD_W-1:0] mod_sec;
  logic [SOD_W-1:0] sec_diff;

  always_comb begin
    // times sixty as shift and subtract
    hour_min = ({6'd0, hour} << 6) - ({6'd0, hour} << 2);
    mod_sec  = ({6'd0, mod} << 6) - ({6'd0, mod} << 2);
    min_diff = mod - hour_min;
    sec_diff = sod - mod_sec;
    minute   = min_diff[MINUTE_W-1:0];
    second   = sec_diff[SECOND_W-1:0];
  end

endmodule

// ----- src/epoch_seconds_to_calendar_date.sv -----
// Seconds since 1970 to GPS-based calendar date and time of day.
// The result beat passes the input register, stages 1 to 3 and the result register.
// Throughput: one beat per cycle while out_tready allows; each of the five registers
// advances when the one after it is free; no stage feeds one multiply into another.
// Reset clears every stage valid bit; payload registers are not reset.
`include "epoch_seconds_to_calendar_date_defines.svh"

module epoch_seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] year, [15:12] month, [20:16] day,
                                  // [25:21] hour, [31:26] minute, [37:32] second,
                                  // [39:38] zero
  output logic        out_tuser   // [0] valid_res
);
  import escd_pkg::*;

  // Stage valid bits and ready chain
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy_out;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0)    v0_r        <= in_tvalid;
      if (rdy1)    v1_r        <= v0_r;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // Input register
  logic [SECS_W-1:0] secs_r;

  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      secs_r <= in_tdata;
    end
  end

  // Stage 1: rebase and divide by seconds per day
  logic              s1_pre_nxt, s1_pre_r;
  logic [SECS_W-1:0] g;
  logic [24:0]       s1_q_nxt, s1_q_r;
  logic [6:0]        s1_glo_nxt, s1_glo_r;
  logic [50:0]       day_prod;
  logic [DAYS_W-1:0] s1_days_nxt, s1_days_r;

  always_comb begin
    s1_pre_nxt  = secs_r < GPS_OFFSET;
    g           = secs_r - GPS_OFFSET;
    s1_q_nxt    = g[31:7];
    s1_glo_nxt  = g[6:0];
    day_prod    = {26'd0, s1_q_nxt} * {25'd0, DAY_RECIP};
    s1_days_nxt = day_prod[DAY_SHIFT +: DAYS_W];
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      s1_pre_r  <= s1_pre_nxt;
      s1_q_r    <= s1_q_nxt;
      s1_glo_r  <= s1_glo_nxt;
      s1_days_r <= s1_days_nxt;
    end
  end

  // Stage 2: second of day, four-year periods
  logic [24:0]        day_odd;
  logic [24:0]        rem_odd;
  logic [SOD_W-1:0]   s2_sod_nxt, s2_sod_r;
  logic [DAYS_W-1:0]  s2_tm1_nxt, s2_tm1_r;
  logic [31:0]        quad_prod;
  logic [QUAD_W-1:0]  s2_k_nxt, s2_k_r;
  logic               s2_pre_r;

  always_comb begin
    day_odd    = {9'd0, s1_days_r} * DAY_ODD;
    rem_odd    = s1_q_r - day_odd;
    s2_sod_nxt = {rem_odd[9:0], s1_glo_r};
    s2_tm1_nxt = s1_days_r + DAY_BIAS;
    quad_prod  = {16'd0, s2_tm1_nxt} * {16'd0, QUAD_RECIP};
    s2_k_nxt   = quad_prod[QUAD_SHIFT +: QUAD_W];
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_pre_r <= s1_pre_r;
      s2_sod_r <= s2_sod_nxt;
      s2_tm1_r <= s2_tm1_nxt;
      s2_k_r   <= s2_k_nxt;
    end
  end

  // Stage 3: day within period, hour and minute of day
  logic [DAYS_W-1:0] quad_span;
  logic [DAYS_W-1:0] qd_full;
  logic [QD_W-1:0]   s3_qd_nxt, s3_qd_r;
  logic [25:0]       hour_prod;
  logic [HOUR_W-1:0] s3_hour_nxt, s3_hour_r;
  logic [30:0]       mod_prod;
  logic [MOD_W-1:0]  s3_mod_nxt, s3_mod_r;
  logic [SOD_W-1:0]  s3_sod_r;
  logic [QUAD_W-1:0] s3_k_r;
  logic              s3_pre_r;

  always_comb begin
    quad_span   = {11'd0, s2_k_r} * QUAD_DAYS;
    qd_full     = s2_tm1_r - quad_span;
    s3_qd_nxt   = qd_full[QD_W-1:0];
    hour_prod   = {13'd0, s2_sod_r[16:4]} * {13'd0, HOUR_RECIP};
    s3_hour_nxt = hour_prod[HOUR_SHIFT +: HOUR_W];
    mod_prod    = {16'd0, s2_sod_r[16:2]} * {15'd0, MOD_RECIP};
    s3_mod_nxt  = mod_prod[MOD_SHIFT +: MOD_W];
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_pre_r  <= s2_pre_r;
      s3_sod_r  <= s2_sod_r;
      s3_k_r    <= s2_k_r;
      s3_qd_r   <= s3_qd_nxt;
      s3_hour_r <= s3_hour_nxt;
      s3_mod_r  <= s3_mod_nxt;
    end
  end

  // Stage 4: calendar date and clock fields into the result register
  date_t                date;
  logic [MINUTE_W-1:0]  minute;
  logic [SECOND_W-1:0]  second;
  logic [OUT_DATA_W-1:0] out_tdata_nxt, out_tdata_r;
  logic                 out_tuser_nxt, out_tuser_r;

  escd_date u_date (
    .quad     (s3_k_r),
    .quad_day (s3_qd_r),
    .date     (date)
  );

  escd_tod u_tod (
    .sod    (s3_sod_r),
    .hour   (s3_hour_r),
    .mod    (s3_mod_r),
    .minute (minute),
    .second (second)
  );

  always_comb begin
    // zero every field before the GPS epoch
    if (s3_pre_r) begin
      out_tdata_nxt = '0;
      out_tuser_nxt = 1'b0;
    end else begin
      out_tdata_nxt = {2'b00, second, minute, s3_hour_r, date.day, date.month, date.year};
      out_tuser_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3_r) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  `ESCD_ASSERT_IMP(a_invalid_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `ESCD_ASSERT_IMP(a_date_range, out_tvalid && out_tuser,
                   out_tdata[15:12] != 4'd0 && out_tdata[15:12] <= 4'd12 &&
                   out_tdata[20:16] != 5'd0 && out_tdata[25:21] <= 5'd23 &&
                   out_tdata[31:26] <= 6'd59 && out_tdata[37:32] <= 6'd59)
  `ESCD_ASSERT_IMP(a_full_stalls, v0_r && v1_r && v2_r && v3_r && out_tvalid && !out_tready,
                   !in_tready)
  `ESCD_ASSERT_NXT(a_drain, v3_r && rdy_out, out_tvalid)

endmodule
